[hdl/hsm_pkg.sv]
// Shared constants, types and round functions for the HMAC-SHA256 block.
`timescale 1ns / 1ps
package hsm_pkg;

   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5c;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int unsigned NUM_KEY_REGS = 8;
   localparam int unsigned CSR_ADDR_W = 3;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] hash_type;

   localparam hash_type INIT_HASH = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type rotr(input word_type v, input int unsigned s);
      return (v >> s) | (v << (32 - s));
   endfunction

endpackage

[hdl/hsm_core.sv]
// SHA-256 compression engine: one round per cycle over a 16-word schedule window.
`timescale 1ns / 1ps
module hsm_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  hsm_pkg::hash_type  chain_in,
   input  logic [511:0]       block_in,
   output logic               done,
   output hsm_pkg::hash_type  hash_out
);

   logic                     busy_ff, busy_in;
   logic [5:0]               rnd_ff, rnd_in;
   hsm_pkg::word_type [15:0] w_ff, w_in;
   hsm_pkg::hash_type        r_ff, r_in;
   hsm_pkg::hash_type        base_ff, base_in;
   logic                     done_ff, done_in;

   hsm_pkg::word_type t1, t2, s0, s1, wnext;

   always_comb begin
      t1 = r_ff[7] + (hsm_pkg::rotr(r_ff[4], 6) ^ hsm_pkg::rotr(r_ff[4], 11)
           ^ hsm_pkg::rotr(r_ff[4], 25)) + ((r_ff[4] & r_ff[5]) ^ (~r_ff[4] & r_ff[6]))
           + hsm_pkg::round_k(rnd_ff) + w_ff[0];
      t2 = (hsm_pkg::rotr(r_ff[0], 2) ^ hsm_pkg::rotr(r_ff[0], 13)
           ^ hsm_pkg::rotr(r_ff[0], 22))
           + ((r_ff[0] & r_ff[1]) ^ (r_ff[0] & r_ff[2]) ^ (r_ff[1] & r_ff[2]));
      s0 = hsm_pkg::rotr(w_ff[1], 7) ^ hsm_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = hsm_pkg::rotr(w_ff[14], 17) ^ hsm_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnext = w_ff[0] + s0 + w_ff[9] + s1;
   end

   always_comb begin
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      w_in    = w_ff;
      r_in    = r_ff;
      base_in = base_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         rnd_in  = '0;
         base_in = chain_in;
         r_in    = chain_in;
         for (int i = 0; i < 16; i++) begin
            w_in[i] = block_in[511 - 32*i -: 32];
         end
      end else if (busy_ff) begin
         r_in = {r_ff[6:4], r_ff[3] + t1, r_ff[2:0], t1 + t2};
         w_in = {wnext, w_ff[15:1]};
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rnd_ff  <= rnd_in;
      w_ff    <= w_in;
      r_ff    <= r_in;
      base_ff <= base_in;
   end

   assign done = done_ff;
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         hash_out[i] = base_ff[i] + r_ff[i];
      end
   end

endmodule

[hdl/hmac_sha256_mac.sv]
// HMAC-SHA256 top level: byte packing, padding sequencer and digest output.
// A data word passes through the byte state, and through a compression when it fills a block.
// The first word of a message first absorbs the inner key block.
// A last word runs up to four compressions, then emits eight
// digest words, one per cycle as the sink accepts. All rounds share one core.
// Synchronous active-high reset clears the sequencer, key registers and lengths.
`timescale 1ns / 1ps
module hmac_sha256_mac (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte
   input  logic        req_tuser,  // has_byte
   input  logic        req_tlast,  // last_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // digest_word[31:0], word_index[34:32], zero fill
   output logic        rsp_tlast,  // last_word
   input  logic        csr_we,
   input  logic [hsm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [63:0] csr_wdata
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_IKEY   = 10'b0000000010,
      ST_BYTE   = 10'b0000000100,
      ST_PAD    = 10'b0000001000,
      ST_PAD2   = 10'b0000010000,
      ST_OKEY   = 10'b0000100000,
      ST_OMSG   = 10'b0001000000,
      ST_WAIT   = 10'b0010000000,
      ST_OUT    = 10'b0100000000,
      ST_FULL   = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in, ret_ff, ret_in;
   logic [63:0]       key_ff [hsm_pkg::NUM_KEY_REGS];
   logic [511:0]      blk_ff, blk_in;
   logic [5:0]        fill_ff, fill_in;
   logic [63:0]       len_ff, len_in;
   logic              absorbed_ff, absorbed_in;
   logic              last_ff, last_in;
   hsm_pkg::hash_type chain_ff, chain_in, inner_ff, inner_in;
   logic [2:0]        idx_ff, idx_in;
   logic              start;
   logic              core_done;
   hsm_pkg::hash_type core_hash;
   logic [511:0]      key_blk_i, key_blk_o;

   // the core latches the block and chain being set up in the start cycle
   hsm_core u_core (
      .clock(clock), .reset(reset), .start(start), .chain_in(chain_in),
      .block_in(blk_in), .done(core_done), .hash_out(core_hash));

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         for (int b = 0; b < 8; b++) begin
            key_blk_i[511 - 64*i - 8*b -: 8] = key_ff[i][63 - 8*b -: 8] ^ hsm_pkg::IPAD;
            key_blk_o[511 - 64*i - 8*b -: 8] = key_ff[i][63 - 8*b -: 8] ^ hsm_pkg::OPAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) key_ff[i] <= '0;
      end else if (csr_we) begin
         key_ff[csr_addr] <= csr_wdata;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, idx_ff, chain_ff[idx_ff]};
   assign rsp_tlast  = (idx_ff == 3'd7);

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      blk_in      = blk_ff;
      fill_in     = fill_ff;
      len_in      = len_ff;
      absorbed_in = absorbed_ff;
      last_in     = last_ff;
      chain_in    = chain_ff;
      inner_in    = inner_ff;
      idx_in      = idx_ff;
      start       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (req_tuser || req_tlast)) begin
               last_in = req_tlast;
               blk_in[511 - 8*fill_ff -: 8] = req_tdata;
               if (!absorbed_ff) begin
                  blk_in   = key_blk_i;
                  chain_in = hsm_pkg::INIT_HASH;
                  state_in = ST_IKEY;
                  // hold the byte in inner_ff[0] until the key block is done
                  inner_in[0] = {req_tdata, 24'd0};
                  len_in   = 64'd512;
                  fill_in  = '0;
               end else begin
                  state_in = ST_BYTE;
               end
               if (req_tuser && absorbed_ff) begin
                  len_in  = len_ff + 64'd8;
                  fill_in = fill_ff + 6'd1;
               end
               if (!req_tuser) state_in = absorbed_ff ? ST_PAD : ST_IKEY;
               absorbed_in = 1'b1;
               ret_in = req_tuser ? ST_BYTE : ST_PAD;
            end
         end
         ST_IKEY: begin
            start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_BYTE: begin
            // key block done: place the pending byte
            if (ret_ff == ST_BYTE && fill_ff == 6'd0 && len_ff == 64'd512) begin
               blk_in[511 -: 8] = inner_ff[0][31:24];
               fill_in = 6'd1;
               len_in  = 64'd520;
            end
            ret_in = ST_IDLE;
            if ((fill_in == 6'd0) && (len_in != 64'd512)) begin
               start = 1'b1;
               ret_in = last_ff ? ST_PAD : ST_IDLE;
               state_in = ST_WAIT;
            end else begin
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            blk_in[511 - 8*fill_ff -: 8] = hsm_pkg::PAD_BYTE;
            for (int i = 0; i < 64; i++) begin
               if (i > fill_ff) blk_in[511 - 8*i -: 8] = 8'd0;
            end
            if (fill_ff < 6'd56) begin
               blk_in[63:0] = len_ff;
               ret_in = ST_OKEY;
            end else begin
               ret_in = ST_PAD2;
            end
            start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_PAD2: begin
            blk_in = {448'd0, len_ff};
            ret_in = ST_OKEY;
            start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_OKEY: begin
            inner_in = chain_ff;
            chain_in = hsm_pkg::INIT_HASH;
            blk_in   = key_blk_o;
            ret_in   = ST_OMSG;
            start    = 1'b1;
            state_in = ST_WAIT;
         end
         ST_OMSG: begin
            for (int i = 0; i < 8; i++) blk_in[511 - 32*i -: 32] = inner_ff[i];
            blk_in[255:0] = {hsm_pkg::PAD_BYTE, 184'd0, 64'd768};
            ret_in   = ST_FULL;
            start    = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (core_done) begin
               chain_in = core_hash;
               state_in = ret_ff;
            end
         end
         ST_FULL: begin
            idx_in   = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in    = ST_IDLE;
                  chain_in    = hsm_pkg::INIT_HASH;
                  fill_in     = '0;
                  len_in      = '0;
                  absorbed_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ret_ff      <= ST_IDLE;
         fill_ff     <= '0;
         len_ff      <= '0;
         absorbed_ff <= 1'b0;
         last_ff     <= 1'b0;
         chain_ff    <= hsm_pkg::INIT_HASH;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         fill_ff     <= fill_in;
         len_ff      <= len_in;
         absorbed_ff <= absorbed_in;
         last_ff     <= last_in;
         chain_ff    <= chain_in;
         idx_ff      <= idx_in;
      end
      blk_ff   <= blk_in;
      inner_ff <= inner_in;
   end

endmodule

[tb/hmac_checker.sv]
// Checker for the HMAC-SHA256 block: predicts digest words from accepted bytes and compares.
`timescale 1ns / 1ps
module hmac_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [hsm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [63:0] csr_wdata,
   output int          fail_count,
   output int          pending_words
);

   typedef struct packed {
      logic [31:0] digest;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [63:0]     key_reg [8];
   logic [31:0]     chain [8];
   logic [7:0]      blk [64];
   int              fill;
   logic [63:0]     msg_bits;
   logic            key_in;
   digest_word_type expected_words [$];

   function automatic logic [31:0] ror(logic [31:0] v, int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   task automatic compress();
      logic [31:0] w [64];
      logic [31:0] r [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      r = chain;
      for (int i = 0; i < 64; i++) begin
         t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
              + ((r[4] & r[5]) ^ (~r[4] & r[6])) + K_TAB[i] + w[i];
         t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
              + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
         r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
         r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += r[i];
   endtask

   task automatic start_keyed(logic [7:0] pad);
      for (int i = 0; i < 8; i++) chain[i] = hsm_pkg::INIT_HASH[i];
      for (int i = 0; i < 64; i++) blk[i] = key_reg[i/8][63-8*(i%8) -: 8] ^ pad;
      compress();
   endtask

   task automatic pad_finish(logic [63:0] len);
      blk[fill] = hsm_pkg::PAD_BYTE;
      fill++;
      if (fill > 56) begin
         while (fill < 64) begin blk[fill] = 8'h00; fill++; end
         compress();
         fill = 0;
      end
      while (fill < 56) begin blk[fill] = 8'h00; fill++; end
      for (int i = 0; i < 8; i++) blk[56+i] = len[63-8*i -: 8];
      compress();
      fill = 0;
   endtask

   task automatic absorb_word(logic [7:0] data, logic has, logic last);
      logic [31:0] inner [8];
      digest_word_type dw;
      if (!has && !last) return;
      if (!key_in) begin
         start_keyed(hsm_pkg::IPAD);
         fill = 0; msg_bits = 64'd512; key_in = 1'b1;
      end
      if (has) begin
         blk[fill] = data;
         fill++;
         msg_bits += 64'd8;
         if (fill == 64) begin compress(); fill = 0; end
      end
      if (!last) return;
      pad_finish(msg_bits);
      inner = chain;
      start_keyed(hsm_pkg::OPAD);
      for (int i = 0; i < 32; i++) blk[i] = inner[i/4][31-8*(i%4) -: 8];
      fill = 32;
      pad_finish(64'd768);
      for (int i = 0; i < 8; i++) begin
         dw.digest = chain[i]; dw.index = 3'(i); dw.last = (i == 7);
         expected_words.insert(expected_words.size(), dw);
      end
      for (int i = 0; i < 8; i++) chain[i] = hsm_pkg::INIT_HASH[i];
      fill = 0; msg_bits = '0; key_in = 1'b0;
   endtask

   always @(posedge clock) begin
      digest_word_type exp_w;
      if (reset) begin
         for (int i = 0; i < 8; i++) key_reg[i] = '0;
         fill = 0; msg_bits = '0; key_in = 1'b0;
         expected_words.delete();
      end else begin
         if (req_tvalid && req_tready) absorb_word(req_tdata, req_tuser, req_tlast);
         if (csr_we) key_reg[csr_addr] = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected digest word %h idx %0d", rsp_tdata[31:0],
                           rsp_tdata[34:32]);
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_tdata[31:0] !== exp_w.digest || rsp_tdata[34:32] !== exp_w.index
                   || rsp_tlast !== exp_w.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                              exp_w.digest, exp_w.index, exp_w.last,
                              rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
               end
            end
         end
      end
      pending_words = expected_words.size();
   end
endmodule

[tb/testbench.sv]
// Top of the HMAC-SHA256 testbench: clock, reset, byte stimulus, key writes and verdict.
`timescale 1ns / 1ps
module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [hsm_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [63:0] csr_wdata = '0;
   int          fail_count;
   int          pending_words;
   int          stall_cnt;
   bit          quiet_phase = 1'b0;
   bit          hold_sink = 1'b0;

   localparam int STALL_LIMIT = 20000;

   hmac_sha256_mac u_top (.*);
   hmac_checker u_chk (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_word(logic [7:0] data, logic has, logic last);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 14);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= has;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_message(int len, bit noise);
      for (int i = 0; i < len; i++) begin
         if (noise && $urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         send_word(8'($urandom), 1'b1, (i == len - 1));
      end
      if (len == 0) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_key(logic [63:0] words [8]);
      for (int i = 0; i < hsm_pkg::NUM_KEY_REGS; i++) begin
         csr_we <= 1'b1;
         csr_addr <= i[hsm_pkg::CSR_ADDR_W-1:0];
         csr_wdata <= words[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // sink: random stall bursts, no stalls in quiet phase, long hold-off on request
   always @(posedge clock) begin
      int burst;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_sink) begin
         rsp_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         burst = $urandom_range(1, 14);
         repeat (burst - 1) @(posedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("hmac_sha256_mac test failed");
         $finish;
      end
   end

   initial begin
      logic [63:0] key [8];
      int sent;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero key: empty message, single bytes, byte on last, idles
      send_message(0, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'h55, 1'b1, 1'b0);
      send_word(8'haa, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      settle();

      // all-ones key: lengths around pad boundaries
      for (int i = 0; i < 8; i++) key[i] = '1;
      write_key(key);
      send_message(55, 1'b0);
      send_message(56, 1'b0);
      send_message(64, 1'b0);
      settle();

      // key changed mid-message is picked up at finalization
      for (int i = 0; i < 8; i++) key[i] = {$urandom, $urandom};
      write_key(key);
      send_word(8'h12, 1'b1, 1'b0);
      settle();
      key[0] = 64'h0123456789abcdef;
      write_key(key);
      send_word(8'h34, 1'b1, 1'b1);
      settle();

      // long receiver hold-off while messages keep coming
      hold_sink <= 1'b1;
      fork
         begin
            repeat (1500) @(posedge clock);
            hold_sink <= 1'b0;
         end
         begin
            send_message(3, 1'b0);
            send_message(2, 1'b0);
            send_message(4, 1'b0);
         end
      join
      settle();

      sent = 0;
      while (sent < 200) begin
         int len;
         if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 8; i++)
               key[i] = ($urandom_range(0, 1)) ? {$urandom, $urandom} : '0;
            settle();
            write_key(key);
         end
         if (sent > 160) quiet_phase = 1'b1;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 20);
         send_message(len, 1'b1);
         sent += len + 1;
      end
      settle();

      if (fail_count == 0) begin
         $display("hmac_sha256_mac test passed");
      end else begin
         $display("hmac_sha256_mac test failed");
      end
      $finish;
   end
endmodule

[sim.f]
hdl/hsm_pkg.sv
hdl/hsm_core.sv
hdl/hmac_sha256_mac.sv
tb/hmac_checker.sv
tb/testbench.sv
